// File: rtl/amf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// amf_pkg
// Shared types and constants for the array mode finder.
// ----------------------------------------------------------------------------
package amf_pkg;

   localparam int AMF_DEPTH      = 256;
   localparam int AMF_DATA_WIDTH = 32;

   typedef struct packed {
      logic signed [AMF_DATA_WIDTH-1:0] value;
      logic                             last;
   } req_beat_type;

   typedef struct packed {
      logic signed [AMF_DATA_WIDTH-1:0] mode_value;
      logic                             overflow;
   } rsp_beat_type;

   typedef struct packed {
      logic start;
      logic ack;
   } scan_ctl_type;

   typedef struct packed {
      logic                             done;
      logic signed [AMF_DATA_WIDTH-1:0] mode;
   } scan_stat_type;

endpackage
`default_nettype wire

// File: rtl/array_mode_finder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// array_mode_finder
// Collects a set of signed elements and returns the most frequent value,
// the smallest one on ties, with a flag for elements dropped on overflow.
//
//   channel   direction   signals                        payload
//   req       in          req_valid / req_ready          req_beat_type
//   rsp       out         rsp_valid / rsp_ready          rsp_beat_type
//
// Elements load at one beat per cycle into the buffer. After the last beat
// the scan sequencer runs, sweeping the buffer once per stored element
// through its single read port; req_ready is low during that time.
// Reset clears the control state; the buffer itself is not cleared.
// A result held back by rsp_ready does not stop the next set from loading.
// ----------------------------------------------------------------------------
module array_mode_finder
   import amf_pkg::*;
#(
   parameter int DEPTH = AMF_DEPTH
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire req_beat_type req_data,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output rsp_beat_type      rsp_data
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH+1);

   typedef enum logic [0:0] {ST_LOAD, ST_SCAN} state_type;

   state_type     state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic          drop_ff, drop_in;
   logic          start_ff, start_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_beat_type  rsp_data_ff, rsp_data_in;

   logic                             req_fire;
   logic                             room;
   logic                             wr_en;
   logic [AW-1:0]                    rd_addr;
   logic signed [AMF_DATA_WIDTH-1:0] rd_data;
   scan_ctl_type                     scan_ctl;
   scan_stat_type                    scan_stat;

   assign req_ready = (state_ff == ST_LOAD);
   assign req_fire  = req_valid && req_ready;
   assign room      = (count_ff < CW'(DEPTH));
   assign wr_en     = req_fire && room;

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      drop_in        = drop_ff;
      start_in       = 1'b0;
      scan_ctl.start = start_ff;
      scan_ctl.ack   = 1'b0;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_data_in    = rsp_data_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_fire) begin
               if (room) begin
                  count_in = count_ff + CW'(1);
               end else begin
                  drop_in = 1'b1;
               end
               if (req_data.last) begin
                  start_in = 1'b1;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (scan_stat.done && (!rsp_valid_ff || rsp_ready)) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.mode_value = scan_stat.mode;
               rsp_data_in.overflow   = drop_ff;
               scan_ctl.ack           = 1'b1;
               count_in               = '0;
               drop_in                = 1'b0;
               state_in               = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         drop_ff      <= 1'b0;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         drop_ff      <= drop_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   amf_store #(
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (req_data.value),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   amf_scan #(
      .DEPTH (DEPTH)
   ) u_scan (
      .clock   (clock),
      .reset   (reset),
      .ctl     (scan_ctl),
      .count   (count_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .stat    (scan_stat)
   );

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("element count exceeds the buffer depth");

   a_scan_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (count_ff != '0))
      else $error("scan started on an empty set");

   a_rsp_from_scan: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_SCAN))
      else $error("result beat raised outside the scan phase");

endmodule
`default_nettype wire

// File: rtl/amf_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// amf_store
// Element buffer: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module amf_store
   import amf_pkg::*;
#(
   parameter int DEPTH = AMF_DEPTH
) (
   input  wire logic                               clock,
   input  wire logic                               wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]           wr_addr,
   input  wire logic signed [AMF_DATA_WIDTH-1:0]   wr_data,
   input  wire logic [$clog2(DEPTH)-1:0]           rd_addr,
   output logic signed [AMF_DATA_WIDTH-1:0]        rd_data
);

   logic signed [AMF_DATA_WIDTH-1:0] mem [DEPTH];
   logic signed [AMF_DATA_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// File: rtl/amf_scan.sv
`default_nettype none
// ----------------------------------------------------------------------------
// amf_scan
// Counting sequencer: for each stored element it sweeps the buffer, counts
// the equal entries and keeps the value with the highest count, the
// smallest value on ties.
// ----------------------------------------------------------------------------
module amf_scan
   import amf_pkg::*;
#(
   parameter int DEPTH = AMF_DEPTH
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire scan_ctl_type                       ctl,
   input  wire logic [$clog2(DEPTH+1)-1:0]         count,
   output logic [$clog2(DEPTH)-1:0]                rd_addr,
   input  wire logic signed [AMF_DATA_WIDTH-1:0]   rd_data,
   output scan_stat_type                           stat
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH+1);

   typedef enum logic [2:0] {
      S_IDLE, S_KEY, S_LATCH, S_SWEEP, S_EVAL, S_DONE
   } state_type;

   state_type                        state_ff, state_in;
   logic [CW-1:0]                    i_ff, i_in;
   logic [CW-1:0]                    j_ff, j_in;
   logic                             pend_ff, pend_in;
   logic signed [AMF_DATA_WIDTH-1:0] key_ff, key_in;
   logic [CW-1:0]                    run_ff, run_in;
   logic [CW-1:0]                    best_cnt_ff, best_cnt_in;
   logic signed [AMF_DATA_WIDTH-1:0] best_val_ff, best_val_in;
   logic                             hit;

   assign hit = pend_ff && (rd_data == key_ff);

   always_comb begin
      state_in    = state_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      pend_in     = pend_ff;
      key_in      = key_ff;
      run_in      = run_ff;
      best_cnt_in = best_cnt_ff;
      best_val_in = best_val_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (ctl.start) begin
               i_in        = '0;
               best_cnt_in = '0;
               state_in    = S_KEY;
            end
         end
         S_KEY: begin
            j_in     = '0;
            run_in   = '0;
            pend_in  = 1'b0;
            state_in = S_LATCH;
         end
         S_LATCH: begin
            key_in   = rd_data;
            j_in     = CW'(1);
            pend_in  = 1'b1;
            state_in = S_SWEEP;
         end
         S_SWEEP: begin
            run_in = run_ff + CW'(hit);
            if (j_ff < count) begin
               j_in    = j_ff + CW'(1);
               pend_in = 1'b1;
            end else begin
               pend_in  = 1'b0;
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            if ((run_ff > best_cnt_ff) ||
                ((run_ff == best_cnt_ff) && (key_ff < best_val_ff))) begin
               best_cnt_in = run_ff;
               best_val_in = key_ff;
            end
            i_in = i_ff + CW'(1);
            if ((i_ff + CW'(1)) == count) begin
               state_in = S_DONE;
            end else begin
               state_in = S_KEY;
            end
         end
         S_DONE: begin
            if (ctl.ack) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
      end
      i_ff        <= i_in;
      j_ff        <= j_in;
      key_ff      <= key_in;
      run_ff      <= run_in;
      best_cnt_ff <= best_cnt_in;
      best_val_ff <= best_val_in;
   end

   assign rd_addr    = (state_ff == S_KEY) ? i_ff[AW-1:0] : j_ff[AW-1:0];
   assign stat.done  = (state_ff == S_DONE);
   assign stat.mode  = best_val_ff;

   a_sweep_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SWEEP) |-> (j_ff <= count))
      else $error("sweep index ran past the element count");

   a_done_counted: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) |-> (best_cnt_ff != '0))
      else $error("scan finished without a counted run");

   a_ack_when_done: assert property (@(posedge clock) disable iff (reset)
      ctl.ack |-> (state_ff == S_DONE))
      else $error("result taken while the scan is not finished");

endmodule
`default_nettype wire
